// ===== rtl/core/hbkr_pkg.sv =====
// shared types and constants for the boot keyboard report builder
// used by hbkr_ctrl, hbkr_dpath and hid_boot_keyboard_report_builder
package hbkr_pkg;

  localparam int MAX_KEYS   = 32;
  localparam int SLOT_COUNT = 6;
  localparam int IDX_W      = $clog2(MAX_KEYS);
  localparam int CNT_W      = $clog2(MAX_KEYS + 1);
  localparam int SLOT_W     = $clog2(SLOT_COUNT);

  localparam logic [7:0] MOD_FIRST     = 8'hE0;
  localparam logic [7:0] ROLLOVER_CODE = 8'h01;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_POLL    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load_in;
    logic scan_start;
    logic scan_run;
    logic scan_finish;
    logic mod_update;
    logic set_rollover;
    logic emit;
  } hbkr_cmd_t;

  typedef struct packed {
    op_e  op;
    logic is_mod;
    logic pending;
    logic many_keys;
    logic scan_done;
    logic out_free;
  } hbkr_sts_t;

endpackage

// ===== rtl/core/hid_boot_keyboard_report_builder.sv =====
// top level of the boot keyboard report builder
// depends on hbkr_pkg, hbkr_ctrl and hbkr_dpath
//
// Input channel (in_valid_i / in_stall_o) carries one request: op_i is key
// press, key release or report poll, key_i the usage code. Output channel
// (out_valid_o / out_stall_i) carries one 7-byte boot report: modifier_o and
// slot0_o..slot5_o. A request is taken only when the block is idle.
// A modifier press or release updates the modifier byte in decode and returns
// to idle. A key press or release walks the held-key memory, one read per cycle
// through a registered read port, and then updates the held count. A poll with a
// change pending reads up to six entries into the staging slots and then loads
// the report register; when more than six keys are held it skips the walk and
// the slots read the rollover code. A poll with nothing pending gives no report.
// Reset clears the held count, modifier byte and pending flag; the memory itself
// is not cleared, the held count marks what is valid.
// A report waits in its register while the receiver stalls; further key
// requests are still taken, and only a following poll with a change pending
// waits for the register.
module hid_boot_keyboard_report_builder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic [7:0] key_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] modifier_o,
  output logic [7:0] slot0_o,
  output logic [7:0] slot1_o,
  output logic [7:0] slot2_o,
  output logic [7:0] slot3_o,
  output logic [7:0] slot4_o,
  output logic [7:0] slot5_o
);
  import hbkr_pkg::*;

  hbkr_cmd_t                  cmd;
  hbkr_sts_t                  sts;
  logic [SLOT_COUNT-1:0][7:0] slots;

  hbkr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hbkr_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op_i),
    .key_i       (key_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .modifier_o  (modifier_o),
    .slots_o     (slots)
  );

  assign slot0_o = slots[0];
  assign slot1_o = slots[1];
  assign slot2_o = slots[2];
  assign slot3_o = slots[3];
  assign slot4_o = slots[4];
  assign slot5_o = slots[5];

endmodule

// ===== rtl/core/hbkr_ctrl.sv =====
// control state machine for the boot keyboard report builder
// depends on hbkr_pkg; drives hbkr_dpath through command and status structs
module hbkr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hbkr_pkg::hbkr_sts_t sts_i,
  output hbkr_pkg::hbkr_cmd_t cmd_o
);
  import hbkr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.scan_start = 1'b1;
        case (sts_i.op)
          OP_PRESS, OP_RELEASE: begin
            if (sts_i.is_mod) begin
              cmd_o.mod_update = 1'b1;
              state_d          = ST_IDLE;
            end else begin
              state_d = ST_SCAN;
            end
          end
          OP_POLL: begin
            if (!sts_i.pending) begin
              state_d = ST_IDLE;
            end else if (sts_i.many_keys) begin
              cmd_o.set_rollover = 1'b1;
              state_d            = ST_EMIT;
            end else begin
              state_d = ST_SCAN;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_done) begin
          if (sts_i.op == OP_POLL) begin
            state_d = ST_EMIT;
          end else begin
            cmd_o.scan_finish = 1'b1;
            state_d           = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/hbkr_dpath.sv =====
// datapath: held-key memory, scan pipeline, modifier byte and report register
// depends on hbkr_pkg; commanded by hbkr_ctrl
module hbkr_dpath (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic [1:0]                                 op_i,
  input  logic [7:0]                                 key_i,
  input  hbkr_pkg::hbkr_cmd_t                        cmd_i,
  output hbkr_pkg::hbkr_sts_t                        sts_o,
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output logic [7:0]                                 modifier_o,
  output logic [hbkr_pkg::SLOT_COUNT-1:0][7:0]       slots_o
);
  import hbkr_pkg::*;

  op_e               op_q;
  logic [7:0]        key_q;
  logic [7:0]        mem [MAX_KEYS];
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [7:0]        mod_q, mod_d;
  logic              pending_q, pending_d;
  logic              found_q, found_d;
  logic              rd_vld_q;
  logic [IDX_W-1:0]  rd_tag_q;
  logic [7:0]        rd_data_q;
  logic              issue;
  logic              hit;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [7:0]        wr_data;
  logic              room;
  logic [SLOT_COUNT-1:0][7:0] stage_q, stage_d;
  logic [SLOT_COUNT-1:0][7:0] out_slot_q;
  logic [7:0]        out_mod_q;
  logic              out_valid_q, out_valid_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= op_e'(op_i);
      key_q <= key_i;
    end
  end

  assign issue = cmd_i.scan_run && (idx_q < count_q);
  assign hit   = rd_vld_q && !found_q && (op_q != OP_POLL) && (rd_data_q == key_q);
  assign room  = count_q < CNT_W'(MAX_KEYS);

  // release: entries after the match move down one place as they stream by
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_tag_q - IDX_W'(1);
    wr_data = rd_data_q;
    if (rd_vld_q && found_q && op_q == OP_RELEASE) begin
      wr_en = 1'b1;
    end else if (cmd_i.scan_finish && op_q == OP_PRESS && !found_q && room) begin
      wr_en   = 1'b1;
      wr_addr = count_q[IDX_W-1:0];
      wr_data = key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data_q <= mem[idx_q[IDX_W-1:0]];
      rd_tag_q  <= idx_q[IDX_W-1:0];
    end
  end

  always_comb begin
    idx_d       = idx_q;
    found_d     = found_q;
    count_d     = count_q;
    mod_d       = mod_q;
    pending_d   = pending_q;
    stage_d     = stage_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.scan_start) begin
      idx_d   = '0;
      found_d = 1'b0;
      stage_d = '0;
    end
    if (cmd_i.set_rollover) begin
      stage_d = {SLOT_COUNT{ROLLOVER_CODE}};
    end
    if (issue) begin
      idx_d = idx_q + CNT_W'(1);
    end
    if (hit) begin
      found_d = 1'b1;
    end
    if (rd_vld_q && op_q == OP_POLL && rd_tag_q < IDX_W'(SLOT_COUNT)) begin
      stage_d[rd_tag_q[SLOT_W-1:0]] = rd_data_q;
    end
    if (cmd_i.mod_update) begin
      if (op_q == OP_PRESS) begin
        mod_d = mod_q | (8'd1 << key_q[2:0]);
      end else begin
        mod_d = mod_q & ~(8'd1 << key_q[2:0]);
      end
      pending_d = 1'b1;
    end
    if (cmd_i.scan_finish) begin
      if (op_q == OP_RELEASE) begin
        pending_d = 1'b1;
        if (found_q) begin
          count_d = count_q - CNT_W'(1);
        end
      end else if (!found_q && room) begin
        count_d   = count_q + CNT_W'(1);
        pending_d = 1'b1;
      end
    end
    if (cmd_i.emit) begin
      pending_d   = 1'b0;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      found_q     <= 1'b0;
      count_q     <= '0;
      mod_q       <= '0;
      pending_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      found_q     <= found_d;
      count_q     <= count_d;
      mod_q       <= mod_d;
      pending_q   <= pending_d;
      rd_vld_q    <= issue;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
    if (cmd_i.emit) begin
      out_mod_q  <= mod_q;
      out_slot_q <= stage_q;
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.is_mod    = key_q[7:3] == MOD_FIRST[7:3];
  assign sts_o.pending   = pending_q;
  assign sts_o.many_keys = count_q > CNT_W'(SLOT_COUNT);
  assign sts_o.scan_done = (idx_q == count_q) && !rd_vld_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign modifier_o  = out_mod_q;
  assign slots_o     = out_slot_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_KEYS))
    else $error("held count beyond capacity");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i))
    else $error("report overwrites one not yet taken");

  a_tag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> ({1'b0, rd_tag_q} < count_q))
    else $error("read beyond held keys");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> !pending_q && out_valid_q)
    else $error("report sent but pending flag kept");
`endif

endmodule

// ===== tb/sv/hid_boot_keyboard_report_builder_tb.sv =====
// self-checking testbench for hid_boot_keyboard_report_builder
// depends on hbkr_pkg and the rtl under rtl/core; a directed table runs first, then random traffic
module hid_boot_keyboard_report_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hbkr_pkg::*;

  localparam int RANDOM_ITEMS = 1150;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 60;

  typedef struct packed {
    logic [7:0] modifier;
    logic [7:0] slot0;
    logic [7:0] slot1;
    logic [7:0] slot2;
    logic [7:0] slot3;
    logic [7:0] slot4;
    logic [7:0] slot5;
  } boot_report_t;

  typedef struct {
    op_e          op;
    logic [7:0]   key;
    bit           typed;
    boot_report_t rep;
  } stim_row_t;

  localparam boot_report_t NO_REPORT = '0;

  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  op_e        op_q     = OP_NONE;
  logic [7:0] key_q    = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] modifier;
  logic [7:0] slot0, slot1, slot2, slot3, slot4, slot5;

  hid_boot_keyboard_report_builder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .op_i        (op_q),
    .key_i       (key_q),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .modifier_o  (modifier),
    .slot0_o     (slot0),
    .slot1_o     (slot1),
    .slot2_o     (slot2),
    .slot3_o     (slot3),
    .slot4_o     (slot4),
    .slot5_o     (slot5)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // keyboard state as the block should hold it
  logic [7:0]   held_keys [MAX_KEYS];
  int unsigned  held_n   = 0;
  logic [7:0]   mod_bits = 8'h00;
  bit           changed  = 1'b0;

  boot_report_t pending_reports [$];
  stim_row_t    stim_table [$];
  int           fails      = 0;
  int           item_count = 0;
  int           burst_left = 0;

  function automatic bit is_mod_key(logic [7:0] key);
    return key[7:3] == MOD_FIRST[7:3];
  endfunction

  function automatic bit key_is_held(logic [7:0] key);
    for (int i = 0; i < held_n; i++) begin
      if (held_keys[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  // returns 1 when the request yields a boot report
  function automatic bit build_report(op_e op, logic [7:0] key, output boot_report_t rep);
    bit         found;
    logic [7:0] s [SLOT_COUNT];
    found = 1'b0;
    rep   = NO_REPORT;
    case (op)
      OP_PRESS: begin
        if (is_mod_key(key)) begin
          mod_bits = mod_bits | (8'h01 << key[2:0]);
          changed  = 1'b1;
        end else if (!key_is_held(key) && held_n < MAX_KEYS) begin
          held_keys[held_n] = key;
          held_n++;
          changed = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (is_mod_key(key)) begin
          mod_bits = mod_bits & ~(8'h01 << key[2:0]);
        end else begin
          for (int i = 0; i < held_n; i++) begin
            if (found) held_keys[i-1] = held_keys[i];
            else if (held_keys[i] == key) found = 1'b1;
          end
          if (found) begin
            held_n--;
            held_keys[held_n] = 8'h00;
          end
        end
        // a release always marks a change, held or not
        changed = 1'b1;
      end
      OP_POLL: begin
        if (changed) begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (held_n > SLOT_COUNT) s[i] = ROLLOVER_CODE;
            else if (i < held_n) s[i] = held_keys[i];
            else s[i] = 8'h00;
          end
          rep     = '{mod_bits, s[0], s[1], s[2], s[3], s[4], s[5]};
          changed = 1'b0;
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic logic [7:0] fresh_key();
    logic [7:0] k;
    do k = 8'($urandom_range(0, 255)); while (is_mod_key(k) || key_is_held(k));
    return k;
  endfunction

  function automatic logic [7:0] any_held_key();
    return held_keys[$urandom_range(0, held_n - 1)];
  endfunction

  function automatic logic [7:0] any_mod_key();
    return MOD_FIRST | 8'($urandom_range(0, 7));
  endfunction

  task automatic add_row(op_e op, logic [7:0] key, bit typed, boot_report_t rep);
    stim_row_t r;
    r.op    = op;
    r.key   = key;
    r.typed = typed;
    r.rep   = rep;
    stim_table.push_back(r);
  endtask

  // sends one request in bursts with random gaps, predicts at acceptance
  task automatic send_request(op_e op, logic [7:0] key, bit typed, boot_report_t typed_rep);
    int           gap;
    boot_report_t rep;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    op_q     <= op;
    key_q    <= key;
    do @(posedge clk); while (in_stall);
    if (build_report(op, key, rep)) begin
      if (typed) rep = typed_rep;
      pending_reports.push_back(rep);
    end
    if (op != OP_NONE) item_count++;
  endtask

  task automatic wait_for_reports();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // receiver: modes of no stall, random stall and long stall runs
  int stall_mode = 0;
  int mode_left  = 0;
  int hold_left  = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 35);
      default: begin
        if (hold_left == 0) begin
          out_stall <= !out_stall;
          hold_left <= $urandom_range(1, 25);
        end else begin
          hold_left <= hold_left - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    boot_report_t exp_rep;
    logic [55:0]  exp_bits;
    logic [55:0]  got_bits;
    string        fname;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("report with none expected: modifier %h slots %h %h %h %h %h %h",
               modifier, slot0, slot1, slot2, slot3, slot4, slot5);
        fails++;
      end else begin
        exp_rep  = pending_reports.pop_front();
        exp_bits = exp_rep;
        got_bits = {modifier, slot0, slot1, slot2, slot3, slot4, slot5};
        for (int i = 0; i < 7; i++) begin
          fname = (i == 0) ? "modifier" : $sformatf("slot%0d", i - 1);
          if (exp_bits[55-8*i -: 8] !== got_bits[55-8*i -: 8]) begin
            $error("%s: expected %h, got %h", fname, exp_bits[55-8*i -: 8],
                   got_bits[55-8*i -: 8]);
            fails++;
          end
        end
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int         pick;
    int         seq_len;
    logic [7:0] k;
    for (int i = 0; i < MAX_KEYS; i++) held_keys[i] = 8'h00;

    add_row(OP_POLL,    8'h00, 1'b0, NO_REPORT);
    add_row(OP_PRESS,   8'hE0, 1'b0, NO_REPORT);
    add_row(OP_POLL,    8'h00, 1'b1, '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    add_row(OP_PRESS,   8'hE7, 1'b0, NO_REPORT);
    add_row(OP_RELEASE, 8'hE0, 1'b0, NO_REPORT);
    add_row(OP_POLL,    8'hFF, 1'b1, '{8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    // modifier already down still marks a change
    add_row(OP_PRESS,   8'hE7, 1'b0, NO_REPORT);
    add_row(OP_POLL,    8'h00, 1'b1, '{8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    add_row(OP_RELEASE, 8'hE7, 1'b0, NO_REPORT);
    add_row(OP_PRESS,   8'h00, 1'b0, NO_REPORT);
    add_row(OP_PRESS,   8'hFF, 1'b0, NO_REPORT);
    add_row(OP_PRESS,   8'hFF, 1'b0, NO_REPORT);
    add_row(OP_POLL,    8'h00, 1'b1, '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
    add_row(OP_POLL,    8'h00, 1'b0, NO_REPORT);
    add_row(OP_RELEASE, 8'h55, 1'b0, NO_REPORT);
    add_row(OP_POLL,    8'h00, 1'b1, '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
    add_row(OP_NONE,    8'hAA, 1'b0, NO_REPORT);
    add_row(OP_POLL,    8'h00, 1'b0, NO_REPORT);
    for (int i = 4; i <= 8; i++) add_row(OP_PRESS, 8'(i), 1'b0, NO_REPORT);
    add_row(OP_POLL,    8'h00, 1'b1, '{8'h00, ROLLOVER_CODE, ROLLOVER_CODE, ROLLOVER_CODE,
                                       ROLLOVER_CODE, ROLLOVER_CODE, ROLLOVER_CODE});
    add_row(OP_RELEASE, 8'h00, 1'b0, NO_REPORT);
    add_row(OP_POLL,    8'h00, 1'b0, NO_REPORT);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) begin
      send_request(stim_table[i].op, stim_table[i].key, stim_table[i].typed, stim_table[i].rep);
    end
    wait_for_reports();

    item_count = 0;
    while (item_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 7) begin
        // fill the list, push past full, then empty it in random order
        while (held_n < MAX_KEYS) begin
          if ($urandom_range(0, 9) == 0) send_request(OP_POLL, 8'h00, 1'b0, NO_REPORT);
          send_request(OP_PRESS, fresh_key(), 1'b0, NO_REPORT);
        end
        send_request(OP_POLL, 8'h00, 1'b0, NO_REPORT);
        repeat ($urandom_range(1, 3)) send_request(OP_PRESS, fresh_key(), 1'b0, NO_REPORT);
        send_request(OP_PRESS, any_held_key(), 1'b0, NO_REPORT);
        send_request(OP_POLL, 8'h00, 1'b0, NO_REPORT);
        while (held_n > 0) begin
          send_request(OP_RELEASE, any_held_key(), 1'b0, NO_REPORT);
          if ($urandom_range(0, 4) == 0) send_request(OP_POLL, 8'h00, 1'b0, NO_REPORT);
        end
        send_request(OP_POLL, 8'h00, 1'b0, NO_REPORT);
      end else if (pick < 85) begin
        seq_len = $urandom_range(5, 30);
        repeat (seq_len) begin
          pick = $urandom_range(0, 99);
          if (pick >= 25 && pick < 55 && held_n >= 12) pick = 80;
          if (pick < 25) begin
            send_request(OP_POLL, 8'($urandom_range(0, 255)), 1'b0, NO_REPORT);
          end else if (pick < 55) begin
            send_request(OP_PRESS, fresh_key(), 1'b0, NO_REPORT);
          end else if (pick < 65) begin
            send_request(OP_PRESS, any_mod_key(), 1'b0, NO_REPORT);
          end else if (pick < 72) begin
            k = (held_n > 0) ? any_held_key() : 8'($urandom_range(0, 255));
            send_request(OP_PRESS, k, 1'b0, NO_REPORT);
          end else if (pick < 90) begin
            k = (held_n > 0) ? any_held_key() : 8'($urandom_range(0, 255));
            send_request(OP_RELEASE, k, 1'b0, NO_REPORT);
          end else if (pick < 95) begin
            send_request(OP_RELEASE, any_mod_key(), 1'b0, NO_REPORT);
          end else begin
            send_request(OP_RELEASE, 8'($urandom_range(0, 255)), 1'b0, NO_REPORT);
          end
        end
      end else begin
        repeat ($urandom_range(3, 10)) begin
          send_request(op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0,
                       NO_REPORT);
        end
      end
      if ($urandom_range(0, 9) == 0) wait_for_reports();
    end

    wait_for_reports();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
